[rtl/reserved_pool_admission_counter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the reserved pool admission counter
// Clocked concurrent assertion forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef RESERVED_POOL_ADMISSION_COUNTER_TOP_ASSERT_SVH
`define RESERVED_POOL_ADMISSION_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define RPAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define RPAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rpac_pkg.sv]
// ----------------------------------------------------------------------------
// rpac_pkg
// Shared constants, codes and widths of the reserved pool admission counter.
// ----------------------------------------------------------------------------
package rpac_pkg;

  // Default number of classes, class 0 being the shared pool
  localparam int NUM_CLASSES_DEF = 4;
  // Classes that have configuration registers (0..3)
  localparam int CFG_CLASSES     = 4;

  localparam int CNT_W    = 11;
  localparam int LIMIT_W  = 10;
  localparam int KIND_W   = 2;
  localparam int CLS_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Class kinds; the fourth code decodes as normal only
  localparam logic [KIND_W-1:0] KIND_NORMAL_ONLY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NORMAL_FIRST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVED_FIRST = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXCEEDED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C1_KIND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C1_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C2_KIND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C2_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C3_KIND      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C3_LIMIT     = 3'd6;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] NORMAL_LIMIT_RST = 10'd100;
  localparam logic [KIND_W-1:0]  C1_KIND_RST      = KIND_NORMAL_FIRST;
  localparam logic [KIND_W-1:0]  C2_KIND_RST      = KIND_RESERVED_FIRST;
  localparam logic [KIND_W-1:0]  C3_KIND_RST      = KIND_RESERVED_FIRST;

endpackage

[rtl/reserved_pool_admission_counter_top.sv]
// ----------------------------------------------------------------------------
// reserved_pool_admission_counter_top
// Slot admission control over a shared pool and up to three reserved classes.
// ----------------------------------------------------------------------------
// Takes acquire or release beats and returns one result beat per request: the
// request sits in an input register, the counter update with its compares and
// the pick of the first normal-first class holding a reserved slot run
// combinationally in the execute stage, and the result lands in an output
// register. Throughput is one request per cycle while the output is not stalled,
// bounded by the single counter read-modify-write in the execute stage. in_tready
// stays high while the input register is empty or the output register is empty or
// being drained. Configuration writes take effect on the next edge and are meant for idle periods.
module reserved_pool_admission_counter_top #(
  parameter int NUM_CLASSES = rpac_pkg::NUM_CLASSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [0] operation, [2:1] client_class, zero above
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rpac_pkg::IN_DATA_W-1:0]   in_tdata,
  // out_tdata: [1:0] status, [11:2] normal_in_use, zero above
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rpac_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [rpac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rpac_pkg::*;

  // Classes that actually count: bounded by the parameter and the registers
  localparam int NUM_ACT = (NUM_CLASSES < CFG_CLASSES) ? NUM_CLASSES : CFG_CLASSES;
  localparam int CNT_IW  = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;

  // Configuration registers; entry k belongs to class k+1
  logic [LIMIT_W-1:0] normal_limit_r;
  logic [KIND_W-1:0]  kind_r  [CFG_CLASSES-1];
  logic [LIMIT_W-1:0] limit_r [CFG_CLASSES-1];

  // Counters
  logic [CNT_W-1:0] cnt_r   [NUM_ACT];
  logic [CNT_W-1:0] cnt_nxt [NUM_ACT];

  // Input stage
  logic             s1_valid_r;
  logic             s1_op_r;
  logic [CLS_W-1:0] s1_cls_r;

  // Output stage
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [LIMIT_W-1:0]  out_normal_r;

  logic out_adv;
  logic fire;

  assign out_adv   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - LIMIT_W){1'b0}}, out_normal_r, out_status_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_limit_r <= NORMAL_LIMIT_RST;
      kind_r[0]      <= C1_KIND_RST;
      kind_r[1]      <= C2_KIND_RST;
      kind_r[2]      <= C3_KIND_RST;
      limit_r[0]     <= '0;
      limit_r[1]     <= '0;
      limit_r[2]     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_LIMIT: normal_limit_r <= cfg_wdata;
        REG_C1_KIND:      kind_r[0]      <= cfg_wdata[KIND_W-1:0];
        REG_C1_LIMIT:     limit_r[0]     <= cfg_wdata;
        REG_C2_KIND:      kind_r[1]      <= cfg_wdata[KIND_W-1:0];
        REG_C2_LIMIT:     limit_r[1]     <= cfg_wdata;
        REG_C3_KIND:      kind_r[2]      <= cfg_wdata[KIND_W-1:0];
        REG_C3_LIMIT:     limit_r[2]     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode the class of the held request
  logic               cls_valid;
  logic [CNT_IW-1:0]  cls_idx;
  logic [KIND_W-1:0]  kind_c;
  logic [LIMIT_W-1:0] limit_c;
  logic [CNT_W-1:0]   cnt_c;

  assign cls_valid = ({1'b0, s1_cls_r} < 3'(NUM_ACT));
  assign cls_idx   = s1_cls_r[CNT_IW-1:0];

  always_comb begin
    unique case (s1_cls_r)
      2'd0: begin
        kind_c  = KIND_NORMAL_ONLY;
        limit_c = '0;
      end
      2'd1: begin
        kind_c  = kind_r[0];
        limit_c = limit_r[0];
      end
      2'd2: begin
        kind_c  = kind_r[1];
        limit_c = limit_r[1];
      end
      default: begin
        kind_c  = kind_r[2];
        limit_c = limit_r[2];
      end
    endcase
  end

  always_comb begin
    cnt_c = '0;
    for (int i = 0; i < NUM_ACT; i++) begin
      if (CNT_IW'(i) == cls_idx) cnt_c = cnt_r[i];
    end
  end

  // Pick the lowest normal-first class holding a reserved slot
  logic              pick_hit;
  logic [CNT_IW-1:0] pick_idx;

  always_comb begin
    pick_hit = 1'b0;
    pick_idx = '0;
    for (int i = NUM_ACT - 1; i >= 1; i--) begin
      if (kind_r[i-1] == KIND_NORMAL_FIRST && cnt_r[i] != '0) begin
        pick_hit = 1'b1;
        pick_idx = CNT_IW'(i);
      end
    end
  end

  // Decide the counter moves and the status
  logic                norm_ok;
  logic                inc0;
  logic                incc;
  logic                decc;
  logic                rel_n;
  logic                dec0;
  logic                dec_pick;
  logic [STATUS_W-1:0] st;

  assign norm_ok = (cnt_r[0] < {1'b0, normal_limit_r});

  always_comb begin
    st       = ST_OK;
    inc0     = 1'b0;
    incc     = 1'b0;
    decc     = 1'b0;
    rel_n    = 1'b0;
    dec0     = 1'b0;
    dec_pick = 1'b0;
    if (cls_valid) begin
      if (s1_op_r == OP_ACQUIRE) begin
        unique case (kind_c)
          KIND_NORMAL_FIRST: begin
            if (norm_ok) inc0 = 1'b1;
            else if (cnt_c >= {1'b0, limit_c} || cnt_c == CNT_MAX) st = ST_EXCEEDED;
            else incc = 1'b1;
          end
          KIND_RESERVED_FIRST: begin
            if (cnt_c == CNT_MAX) st = ST_EXCEEDED;
            else if (cnt_c < {1'b0, limit_c}) incc = 1'b1;
            else if (norm_ok) begin
              inc0 = 1'b1;
              incc = 1'b1;
            end else st = ST_EXCEEDED;
          end
          default: begin
            if (norm_ok) inc0 = 1'b1;
            else st = ST_EXCEEDED;
          end
        endcase
      end else begin
        unique case (kind_c)
          KIND_NORMAL_FIRST: begin
            if (cnt_c != '0) decc = 1'b1;
            else rel_n = 1'b1;
          end
          KIND_RESERVED_FIRST: begin
            if (cnt_c == '0) st = ST_ZERO;
            else begin
              decc  = 1'b1;
              rel_n = (cnt_c > {1'b0, limit_c});
            end
          end
          default: rel_n = 1'b1;
        endcase
      end
      // Free a shared slot: move a borrowing class first, else drop the pool
      if (rel_n) begin
        if (pick_hit) dec_pick = 1'b1;
        else if (cnt_r[0] == '0) st = ST_ZERO;
        else dec0 = 1'b1;
      end
    end
  end

  // Apply the moves to each counter
  always_comb begin
    for (int i = 0; i < NUM_ACT; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (fire) begin
        if ((i == 0 && inc0) || (CNT_IW'(i) == cls_idx && incc)) begin
          cnt_nxt[i] = cnt_r[i] + 1'b1;
        end else if ((i == 0 && dec0) || (CNT_IW'(i) == cls_idx && decc) ||
                     (CNT_IW'(i) == pick_idx && dec_pick)) begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
    end
  end

  // Hold counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ACT; i++) cnt_r[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_ACT; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  // Advance the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tdata[0];
      s1_cls_r <= in_tdata[CLS_W:1];
    end
  end

  // Advance the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= st;
      out_normal_r <= cnt_nxt[0][LIMIT_W-1:0];
    end
  end

endmodule

[rtl/rpac_checker.sv]
// ----------------------------------------------------------------------------
// rpac_checker
// Port-level checks of the admission counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "reserved_pool_admission_counter_top_assert.svh"

module rpac_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rpac_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import rpac_pkg::*;

  logic                in_acc;
  logic                out_acc;
  logic [1:0]          pend_r;
  logic                have_prev_r;
  logic [LIMIT_W-1:0]  prev_r;
  logic [LIMIT_W-1:0]  cur_normal;
  logic [STATUS_W-1:0] cur_status;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign cur_status = out_tdata[STATUS_W-1:0];
  assign cur_normal = out_tdata[STATUS_W+LIMIT_W-1:STATUS_W];

  // Track requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // Hold the shared count of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_r      <= '0;
    end else if (out_acc) begin
      have_prev_r <= 1'b1;
      prev_r      <= cur_normal;
    end
  end

  // A stalled result beat holds its data
  `RPAC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result beat changed")

  // No result beat without a request taken before it
  `RPAC_ASSERT_NOW(a_no_orphan, clk, rst_n, out_tvalid, pend_r != 2'd0,
                   "result beat without a pending request")

  // A refused request, one with a status other than OK, leaves the shared count alone
  `RPAC_ASSERT_NOW(a_refused_keeps, clk, rst_n, out_tvalid && have_prev_r && cur_status != ST_OK,
                   cur_normal == prev_r, "shared count moved on a refused request")

  // The shared count moves by at most one slot per request
  `RPAC_ASSERT_NOW(a_unit_step, clk, rst_n, out_tvalid && have_prev_r,
                   cur_normal == prev_r || cur_normal == 10'(prev_r + 10'd1) || 10'(cur_normal + 10'd1) == prev_r,
                   "shared count jumped")

  // The pending count never exceeds the two pipeline stages
  `RPAC_ASSERT_NOW(a_pend_bound, clk, rst_n, pend_r == 2'd2, !in_tready || out_acc,
                   "request taken with both stages full")

endmodule

bind reserved_pool_admission_counter_top rpac_checker u_rpac_checker (.*);
